>>> rtl/core/indexed_ordered_list_defines.svh
// Assertion macros for the indexed ordered list.
`ifndef INDEXED_ORDERED_LIST_DEFINES_SVH
`define INDEXED_ORDERED_LIST_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define IOL_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled in reset.
`define IOL_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/iol_pkg.sv
`default_nettype none

package iol_pkg;

  typedef enum logic [1:0] {
    FUNC_INSERT = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_READ   = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic load;
    logic ins;
    logic rem;
    logic rd;
  } cell_op_t;

endpackage

`default_nettype wire

>>> rtl/core/iol_if.sv
`default_nettype none

interface iol_req_if #(
  parameter int POS_W  = 7,
  parameter int DATA_W = 32
);
  logic              valid;
  logic              ready;
  logic [1:0]        func;
  logic [POS_W-1:0]  position;
  logic [DATA_W-1:0] value;

  modport source (output valid, func, position, value, input ready);
  modport sink   (input valid, func, position, value, output ready);
endinterface

interface iol_rsp_if #(
  parameter int POS_W  = 7,
  parameter int DATA_W = 32
);
  logic              valid;
  logic              ready;
  logic [DATA_W-1:0] read_value;
  logic [1:0]        status;
  logic [POS_W-1:0]  count;

  modport source (output valid, read_value, status, count, input ready);
  modport sink   (input valid, read_value, status, count, output ready);
endinterface

`default_nettype wire

>>> rtl/core/iol_cell.sv
`default_nettype none

module iol_cell #(
  parameter int INDEX  = 0,
  parameter int POS_W  = 7,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire iol_pkg::cell_op_t op,
  input  wire logic [POS_W-1:0]  pos,
  input  wire logic [DATA_W-1:0] value,
  input  wire logic [DATA_W-1:0] left,
  input  wire logic [DATA_W-1:0] right,
  output logic      [DATA_W-1:0] data,
  output logic      [DATA_W-1:0] rd_word
);
  import iol_pkg::*;

  localparam logic [POS_W-1:0] MY_IDX = POS_W'(INDEX);

  logic above;
  logic hit;

  assign above = MY_IDX > pos;
  assign hit   = MY_IDX == pos;

  always_ff @(posedge clk) begin
    if (op.ins && above) begin
      data <= left;
    end else if (op.ins && hit) begin
      data <= value;
    end else if (op.rem && (above || hit)) begin
      data <= right;
    end
  end

  always_ff @(posedge clk) begin
    if (op.load) begin
      rd_word <= (op.rd && hit) ? data : '0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/indexed_ordered_list.sv
// Indexed ordered list: up to CAPACITY words held in a row of shifting cells.
// req carries func (insert, remove, read), position and value; rsp returns
// read_value, status and the count after the operation, one beat per request.
// A request beat updates every cell at its accept edge: insert moves cells
// above the position up and writes value, remove moves them down, read
// captures the addressed word in a per-cell register. The response is formed
// by an OR over those registers in the next cycle and lands in the output
// register, which raises rsp.valid, once that register is free.
// Throughput is one request per cycle while rsp is taken; the rate is set by
// the one pending slot between the cell row and the output register.
// If rsp stalls, one more request is taken and held pending; req.ready then
// stays low until the output register is freed.
// Reset (rst, synchronous) empties the list and drops pending and output
// beats; req.ready is low while rst is high. Cell contents are not cleared,
// since positions at or above the count are never read.
`default_nettype none
`include "indexed_ordered_list_defines.svh"

module indexed_ordered_list #(
  parameter int CAPACITY   = 64,
  parameter int DATA_WIDTH = 32
) (
  input wire logic clk,
  input wire logic rst,
  iol_req_if.sink   req,
  iol_rsp_if.source rsp
);
  import iol_pkg::*;

  localparam int POS_W = $clog2(CAPACITY + 1);
  localparam logic [POS_W-1:0] CAP = POS_W'(CAPACITY);

  logic [POS_W-1:0]  cnt;
  logic [POS_W-1:0]  cnt_next;
  logic              busy;
  status_t           pend_status;
  logic [POS_W-1:0]  pend_count;
  status_t           status_next;
  logic              acc;
  logic              drain;
  logic              ins_ok;
  logic              rem_ok;
  logic              rd_ok;
  cell_op_t          op;
  logic [DATA_WIDTH-1:0] rd_or;
  logic              rsp_full;
  logic              rsp_err;

  logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
  logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];

  assign drain     = busy && (!rsp.valid || rsp.ready);
  assign req.ready = !rst && (!busy || !rsp.valid || rsp.ready);
  assign acc       = req.valid && req.ready;

  always_comb begin
    ins_ok      = 1'b0;
    rem_ok      = 1'b0;
    rd_ok       = 1'b0;
    status_next = ST_RANGE;
    cnt_next    = cnt;
    case (func_t'(req.func))
      FUNC_INSERT: begin
        if (req.position > cnt) begin
          status_next = ST_RANGE;
        end else if (cnt == CAP) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_OK;
          ins_ok      = 1'b1;
          cnt_next    = cnt + POS_W'(1);
        end
      end
      FUNC_REMOVE: begin
        if (req.position < cnt) begin
          status_next = ST_OK;
          rem_ok      = 1'b1;
          cnt_next    = cnt - POS_W'(1);
        end
      end
      FUNC_READ: begin
        if (req.position < cnt) begin
          status_next = ST_OK;
          rd_ok       = 1'b1;
        end
      end
      default: begin
        status_next = ST_RANGE;
      end
    endcase
  end

  assign op.load = acc;
  assign op.ins  = acc && ins_ok;
  assign op.rem  = acc && rem_ok;
  assign op.rd   = acc && rd_ok;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] left;
    logic [DATA_WIDTH-1:0] right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_mid
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = cell_data[i];
    end else begin : g_body
      assign right = cell_data[i+1];
    end
    iol_cell #(
      .INDEX  (i),
      .POS_W  (POS_W),
      .DATA_W (DATA_WIDTH)
    ) u_cell (
      .clk     (clk),
      .op      (op),
      .pos     (req.position),
      .value   (req.value),
      .left    (left),
      .right   (right),
      .data    (cell_data[i]),
      .rd_word (cell_rd[i])
    );
  end

  always_comb begin
    rd_or = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_or = rd_or | cell_rd[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      busy <= 1'b0;
    end else begin
      if (acc) begin
        cnt <= cnt_next;
      end
      if (acc) begin
        busy <= 1'b1;
      end else if (drain) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend_status <= status_next;
      pend_count  <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (drain) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      rsp.read_value <= rd_or;
      rsp.status     <= pend_status;
      rsp.count      <= pend_count;
    end
  end

  assign rsp_full = rsp.valid && (rsp.status == ST_FULL);
  assign rsp_err  = rsp.valid && (rsp.status != ST_OK);

  `IOL_ASSERT_NOW(a_cnt_bound, clk, rst, 1'b1, cnt <= CAP, "count above capacity")
  `IOL_ASSERT_NEXT(a_ins_grow, clk, rst, op.ins, cnt == $past(cnt) + POS_W'(1), "insert count")
  `IOL_ASSERT_NOW(a_full_cnt, clk, rst, rsp_full, rsp.count == CAP, "full refused below capacity")
  `IOL_ASSERT_NOW(a_err_zero, clk, rst, rsp_err, rsp.read_value == '0, "error beat carries data")

endmodule

`default_nettype wire

>>> test/tb_indexed_ordered_list.sv
`timescale 1ns / 100ps

module tb_indexed_ordered_list;
  import iol_pkg::*;

  localparam int          LIST_DEPTH  = 64;
  localparam int          RANDOM_OPS  = 1750;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;

  typedef struct {
    logic [31:0] read_value;
    status_t     status;
    logic [6:0]  count;
  } list_result_t;

  class list_scoreboard;
    logic [31:0]  words[$];
    list_result_t expected_q[$];
    int           failures;

    function int unsigned held();
      return words.size();
    endfunction

    function void note_request(logic [1:0] f, logic [6:0] p, logic [31:0] v);
      list_result_t r;
      r.read_value = '0;
      r.status     = ST_OK;
      case (f)
        FUNC_INSERT: begin
          if (p > words.size()) r.status = ST_RANGE;
          else if (words.size() >= LIST_DEPTH) r.status = ST_FULL;
          else words.insert(p, v);
        end
        FUNC_REMOVE: begin
          if (p >= words.size()) r.status = ST_RANGE;
          else words.delete(p);
        end
        FUNC_READ: begin
          if (p >= words.size()) r.status = ST_RANGE;
          else r.read_value = words[p];
        end
        default: r.status = ST_RANGE;
      endcase
      r.count = 7'(words.size());
      expected_q.push_back(r);
    endfunction

    function void check_response(logic [31:0] rd, logic [1:0] st, logic [6:0] cnt);
      list_result_t r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected response beat read_value=%h status=%0d count=%0d",
                 $time, rd, st, cnt);
        failures++;
        return;
      end
      r = expected_q.pop_front();
      if (rd !== r.read_value) begin
        $display("%0t: read_value mismatch expected %h actual %h", $time, r.read_value, rd);
        failures++;
      end
      if (st !== r.status) begin
        $display("%0t: status mismatch expected %0d actual %0d", $time, r.status, st);
        failures++;
      end
      if (cnt !== r.count) begin
        $display("%0t: count mismatch expected %0d actual %0d", $time, r.count, cnt);
        failures++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  bit   flat_run;

  list_scoreboard book;

  iol_req_if #(.POS_W(7), .DATA_W(32)) req_bus ();
  iol_rsp_if #(.POS_W(7), .DATA_W(32)) rsp_bus ();

  indexed_ordered_list #(
    .CAPACITY   (LIST_DEPTH),
    .DATA_WIDTH (32)
  ) i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_bus),
    .rsp (rsp_bus)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

  // response sink with random back-pressure
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      rsp_bus.ready <= flat_run ? 1'b1 : ($urandom_range(99) >= 31);
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_bus.valid && rsp_bus.ready)
      book.check_response(rsp_bus.read_value, rsp_bus.status, rsp_bus.count);
  end

  task automatic send_beat(logic [1:0] f, logic [6:0] p, logic [31:0] v);
    while (!flat_run && $urandom_range(99) < 31) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid    <= 1'b1;
    req_bus.func     <= f;
    req_bus.position <= p;
    req_bus.value    <= v;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    book.note_request(f, p, v);
  endtask

  task automatic random_beat(bit growing);
    int unsigned roll;
    int unsigned cnt;
    int unsigned p;
    logic [1:0]  f;
    logic [31:0] v;
    cnt  = book.held();
    roll = $urandom_range(99);
    if (roll < 5) f = FUNC_UNUSED;
    else if (roll < 30) f = FUNC_READ;
    else if (roll < (growing ? 90 : 40)) f = FUNC_INSERT;
    else f = FUNC_REMOVE;
    roll = $urandom_range(99);
    if (roll < 75) begin
      if (f == FUNC_INSERT) p = $urandom_range(cnt);
      else p = (cnt == 0) ? 0 : $urandom_range(cnt - 1);
    end else if (roll < 85) begin
      case ($urandom_range(3))
        0: p = cnt;
        1: p = cnt + 1;
        2: p = LIST_DEPTH;
        default: p = LIST_DEPTH + 1;
      endcase
    end else begin
      p = $urandom_range(127);
    end
    roll = $urandom_range(99);
    if (roll < 10) v = '0;
    else if (roll < 20) v = '1;
    else v = $urandom;
    send_beat(f, p[6:0], v);
  endtask

  initial begin
    book     = new();
    flat_run = 1'b0;
    rst      = 1'b1;
    req_bus.valid    = 1'b0;
    req_bus.func     = FUNC_INSERT;
    req_bus.position = '0;
    req_bus.value    = '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty list, then insert at front, middle and end
    send_beat(FUNC_READ,   7'd0,   32'h1234_5678);
    send_beat(FUNC_REMOVE, 7'd0,   32'h0);
    send_beat(FUNC_INSERT, 7'd1,   32'hDEAD_BEEF);
    send_beat(FUNC_INSERT, 7'd0,   32'hFFFF_FFFF);
    send_beat(FUNC_INSERT, 7'd1,   32'h0000_0000);
    send_beat(FUNC_INSERT, 7'd1,   32'hA5A5_A5A5);
    send_beat(FUNC_INSERT, 7'd0,   32'h0000_0001);
    send_beat(FUNC_READ,   7'd0,   32'h0);
    send_beat(FUNC_READ,   7'd1,   32'h0);
    send_beat(FUNC_READ,   7'd2,   32'h0);
    send_beat(FUNC_READ,   7'd3,   32'h0);
    send_beat(FUNC_READ,   7'd4,   32'h0);
    send_beat(FUNC_READ,   7'd127, 32'hFFFF_FFFF);
    send_beat(FUNC_UNUSED, 7'd0,   32'h5A5A_5A5A);
    send_beat(FUNC_INSERT, 7'd127, 32'h8000_0000);
    send_beat(FUNC_REMOVE, 7'd4,   32'h0);
    send_beat(FUNC_REMOVE, 7'd3,   32'h0);
    send_beat(FUNC_REMOVE, 7'd0,   32'h0);
    send_beat(FUNC_REMOVE, 7'd1,   32'h0);
    send_beat(FUNC_READ,   7'd0,   32'h0);
    send_beat(FUNC_REMOVE, 7'd0,   32'h0);
    send_beat(FUNC_READ,   7'd0,   32'h0);

    // alternate filling and draining so the full list is reached repeatedly
    for (int n = 0; n < RANDOM_OPS; n++) begin
      flat_run = (n >= 800 && n < 1100);
      random_beat(((n / 250) % 2) == 0);
    end
    flat_run = 1'b0;

    req_bus.valid <= 1'b0;
    while (book.expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (book.failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/iol_pkg.sv
rtl/core/iol_if.sv
rtl/core/iol_cell.sv
rtl/core/indexed_ordered_list.sv
test/tb_indexed_ordered_list.sv
